FILE: rtl/tbrl_pkg.sv
package tbrl_pkg;

    localparam int TIME_W  = 64;
    localparam int RATE_W  = 40;
    localparam int LEVEL_W = 48;
    localparam int BYTES_W = 16;
    localparam int ALU_W   = 64;
    localparam int PROD_W  = TIME_W + RATE_W;
    localparam int REM_W   = 30;
    localparam int CNT_W   = 6;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 64;

    localparam int MUL_STEPS = RATE_W;

    localparam logic [ALU_W-1:0] NS_PER_SEC = 64'd1_000_000_000;
    localparam logic [REM_W-1:0] NS_BITS    = 30'd1_000_000_000;
    localparam int               NS_IDX_W   = 5;

    // quotient estimate: ((p >> NHI_LSB) * RECIP_NS) >> RECIP_SHIFT, low by at most one
    // for any product below 2^48 * 1e9
    localparam int                 RECIP_W     = 51;
    localparam logic [RECIP_W-1:0] RECIP_NS    = 51'd1208925819614629;
    localparam int                 RECIP_SHIFT = 52;
    localparam int                 NHI_LSB     = 28;
    localparam int                 NHI_W       = 50;
    localparam int                 QUOT_LSB    = RECIP_SHIFT + (PROD_W - ALU_W) - RECIP_W;

    // register index, taken from paddr[3]
    localparam logic REG_RATE  = 1'b0;
    localparam logic REG_BURST = 1'b1;

    typedef struct packed {
        logic [RATE_W-1:0]  rate;
        logic [LEVEL_W-1:0] burst;
    } cfg_t;

    typedef struct packed {
        logic             sub;
        logic             cin;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

endpackage

FILE: rtl/tbrl_alu.sv
module tbrl_alu (
    input  tbrl_pkg::alu_req_t           req,
    output logic [tbrl_pkg::ALU_W:0]     res
);
    import tbrl_pkg::*;

    // bit ALU_W is the carry on add and the borrow on subtract
    always_comb begin
        if (req.sub) begin
            res = {1'b0, req.a} - {1'b0, req.b};
        end else begin
            res = {1'b0, req.a} + {1'b0, req.b} + {{ALU_W{1'b0}}, req.cin};
        end
    end

endmodule

FILE: rtl/tbrl_regs.sv
module tbrl_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbrl_pkg::APB_AW-1:0]   paddr,
    input  logic [tbrl_pkg::APB_DW-1:0]   pwdata,
    output logic [tbrl_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output tbrl_pkg::cfg_t                cfg
);
    import tbrl_pkg::*;

    logic [RATE_W-1:0]  rate_reg;
    logic [LEVEL_W-1:0] burst_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= '0;
            burst_reg <= '0;
        end else if (wr_en) begin
            unique case (paddr[3])
                REG_RATE:  rate_reg  <= pwdata[RATE_W-1:0];
                REG_BURST: burst_reg <= pwdata[LEVEL_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_RATE:  prdata = {{(APB_DW-RATE_W){1'b0}}, rate_reg};
            REG_BURST: prdata = {{(APB_DW-LEVEL_W){1'b0}}, burst_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.rate  = rate_reg;
    assign cfg.burst = burst_reg;

endmodule

FILE: rtl/token_bucket_rate_limiter.sv
// sequence from input transfer to result: restart or unlimited goes straight to output;
//   a request whose time did not advance goes to debit, then output; a refill runs elapsed,
//   multiply and range check, then, unless saturated, reciprocal multiply, residual and
//   correct, then update, cap, debit and output
// throughput: one item at a time, next input taken the cycle after the result transfer;
//   a shared 64-bit add/subtract unit does every step of the refill and debit arithmetic
// reset: aresetn synchronous active low; clears rate, burst, token level and refill time
module token_bucket_rate_limiter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [tbrl_pkg::TIME_W-1:0]    s_now_time_ns,
    input  logic [tbrl_pkg::BYTES_W-1:0]   s_packet_bytes,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_allowed,
    output logic                           m_unlimited,
    output logic [tbrl_pkg::LEVEL_W-1:0]   m_level_bytes,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbrl_pkg::APB_AW-1:0]    paddr,
    input  logic [tbrl_pkg::APB_DW-1:0]    pwdata,
    output logic [tbrl_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import tbrl_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ELAPSED = 4'd1;
    localparam logic [3:0] S_MUL     = 4'd2;
    localparam logic [3:0] S_SAT     = 4'd3;
    localparam logic [3:0] S_RECIP   = 4'd4;
    localparam logic [3:0] S_RESID   = 4'd5;
    localparam logic [3:0] S_FIX     = 4'd6;
    localparam logic [3:0] S_CORR    = 4'd7;
    localparam logic [3:0] S_REFILL  = 4'd8;
    localparam logic [3:0] S_CAP     = 4'd9;
    localparam logic [3:0] S_DEBIT   = 4'd10;
    localparam logic [3:0] S_OUT     = 4'd11;

    cfg_t     cfg;
    alu_req_t alu_req;
    logic [ALU_W:0] alu_res;
    logic           borrow;

    logic [3:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [TIME_W-1:0]  last_reg, last_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [TIME_W-1:0]  res_reg, res_next;
    logic [LEVEL_W:0]   sum_reg, sum_next;
    logic               sat_reg, sat_next;
    logic               corr_reg, corr_next;
    logic               allowed_reg, allowed_next;
    logic               unl_reg, unl_next;

    logic [LEVEL_W-1:0]  eff_burst;
    logic                unl;
    logic [NS_IDX_W-1:0] ns_idx;
    logic [LEVEL_W-1:0]  quot;

    tbrl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbrl_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign borrow    = alu_res[ALU_W];
    assign unl       = (cfg.rate == '0);
    assign eff_burst = (cfg.burst != '0) ? cfg.burst
                                         : {{(LEVEL_W-RATE_W){1'b0}}, cfg.rate};
    assign ns_idx    = NS_IDX_W'(REM_W - 1) - cnt_reg[NS_IDX_W-1:0];
    assign quot      = prod_reg[QUOT_LSB+LEVEL_W-1:QUOT_LSB];

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = (state_reg == S_OUT);
    assign m_allowed     = allowed_reg;
    assign m_unlimited   = unl_reg;
    assign m_level_bytes = level_reg;

    // operand select for the shared unit
    always_comb begin
        alu_req = '0;
        unique case (state_reg)
            S_ELAPSED: begin
                alu_req.sub = 1'b1;
                alu_req.a   = now_reg;
                alu_req.b   = last_reg;
            end
            S_MUL: begin
                alu_req.sub = 1'b0;
                alu_req.a   = prod_reg[PROD_W-1:RATE_W];
                alu_req.b   = prod_reg[0] ? elapsed_reg : '0;
            end
            S_SAT: begin
                // product at or above 2^48 * 1e9 saturates the refill
                alu_req.sub = 1'b1;
                alu_req.a   = {{(ALU_W-PROD_W+LEVEL_W){1'b0}}, prod_reg[PROD_W-1:LEVEL_W]};
                alu_req.b   = NS_PER_SEC;
            end
            S_RECIP: begin
                alu_req.sub = 1'b0;
                alu_req.a   = prod_reg[PROD_W-1:RATE_W];
                alu_req.b   = RECIP_NS[cnt_reg] ? elapsed_reg : '0;
            end
            S_RESID: begin
                // estimate times 1e9, msb first
                alu_req.sub = 1'b0;
                alu_req.a   = {elapsed_reg[ALU_W-2:0], 1'b0};
                alu_req.b   = NS_BITS[ns_idx] ? {{(ALU_W-LEVEL_W){1'b0}}, quot} : '0;
            end
            S_FIX: begin
                alu_req.sub = 1'b1;
                alu_req.a   = res_reg;
                alu_req.b   = elapsed_reg;
            end
            S_CORR: begin
                alu_req.sub = 1'b1;
                alu_req.a   = res_reg;
                alu_req.b   = NS_PER_SEC;
            end
            S_REFILL: begin
                alu_req.sub = 1'b0;
                alu_req.cin = corr_reg;
                alu_req.a   = {{(ALU_W-LEVEL_W){1'b0}}, level_reg};
                alu_req.b   = {{(ALU_W-LEVEL_W){1'b0}}, quot};
            end
            S_CAP: begin
                alu_req.sub = 1'b1;
                alu_req.a   = {{(ALU_W-LEVEL_W-1){1'b0}}, sum_reg};
                alu_req.b   = {{(ALU_W-LEVEL_W){1'b0}}, eff_burst};
            end
            S_DEBIT: begin
                alu_req.sub = 1'b1;
                alu_req.a   = {{(ALU_W-LEVEL_W){1'b0}}, level_reg};
                alu_req.b   = {{(ALU_W-BYTES_W){1'b0}}, bytes_reg};
            end
            default: alu_req = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        now_next     = now_reg;
        bytes_next   = bytes_reg;
        last_next    = last_reg;
        level_next   = level_reg;
        elapsed_next = elapsed_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        sum_next     = sum_reg;
        sat_next     = sat_reg;
        corr_next    = corr_reg;
        allowed_next = allowed_reg;
        unl_next     = unl_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    now_next     = s_now_time_ns;
                    bytes_next   = s_packet_bytes;
                    unl_next     = unl;
                    allowed_next = 1'b1;
                    if (s_func) begin
                        level_next = eff_burst;
                        last_next  = s_now_time_ns;
                        state_next = S_OUT;
                    end else if (unl) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_ELAPSED;
                    end
                end
            end
            S_ELAPSED: begin
                // time did not advance: no refill, keep stored time
                if (borrow || alu_res[ALU_W-1:0] == '0) begin
                    state_next = S_DEBIT;
                end else begin
                    elapsed_next = alu_res[ALU_W-1:0];
                    prod_next    = {{TIME_W{1'b0}}, cfg.rate};
                    cnt_next     = '0;
                    state_next   = S_MUL;
                end
            end
            S_MUL: begin
                prod_next = {alu_res, prod_reg[RATE_W-1:1]};
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_SAT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SAT: begin
                sat_next     = ~borrow;
                corr_next    = 1'b0;
                res_next     = prod_reg[TIME_W-1:0];
                elapsed_next = {{(ALU_W-NHI_W){1'b0}}, prod_reg[NHI_LSB+NHI_W-1:NHI_LSB]};
                prod_next    = '0;
                cnt_next     = '0;
                state_next   = borrow ? S_RECIP : S_REFILL;
            end
            S_RECIP: begin
                prod_next = {alu_res, prod_reg[RATE_W-1:1]};
                if (cnt_reg == CNT_W'(RECIP_W - 1)) begin
                    cnt_next     = '0;
                    elapsed_next = '0;
                    state_next   = S_RESID;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_RESID: begin
                elapsed_next = alu_res[ALU_W-1:0];
                if (cnt_reg == CNT_W'(REM_W - 1)) begin
                    cnt_next   = '0;
                    state_next = S_FIX;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIX: begin
                // remainder of the estimate, below 2e9 so the low 64 bits suffice
                res_next   = alu_res[ALU_W-1:0];
                state_next = S_CORR;
            end
            S_CORR: begin
                corr_next  = ~borrow;
                state_next = S_REFILL;
            end
            S_REFILL: begin
                sum_next   = alu_res[LEVEL_W:0];
                state_next = S_CAP;
            end
            S_CAP: begin
                level_next = (sat_reg || !borrow) ? eff_burst : sum_reg[LEVEL_W-1:0];
                last_next  = now_reg;
                state_next = S_DEBIT;
            end
            S_DEBIT: begin
                if (borrow) begin
                    allowed_next = 1'b0;
                end else begin
                    allowed_next = 1'b1;
                    level_next   = alu_res[LEVEL_W-1:0];
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            last_reg  <= '0;
            level_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        bytes_reg   <= bytes_next;
        elapsed_reg <= elapsed_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
        sum_reg     <= sum_next;
        sat_reg     <= sat_next;
        corr_reg    <= corr_next;
        allowed_reg <= allowed_next;
        unl_reg     <= unl_next;
    end

endmodule

FILE: tb/tb.sv
module tb;
    import tbrl_pkg::*;

    localparam logic FN_REQUEST = 1'b0;
    localparam logic FN_RESTART = 1'b1;

    localparam logic [RATE_W-1:0]  RATE_MAX  = '1;
    localparam logic [LEVEL_W-1:0] BURST_MAX = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [TIME_W-1:0]  TIME_HALF = TIME_W'(1) << (TIME_W - 1);
    localparam logic [PROD_W-1:0]  GAIN_CEIL = PROD_W'(1) << LEVEL_W;

    localparam int SETTLE_CYCLES   = 160;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 104;

    typedef struct packed {
        logic               allowed;
        logic               unlimited;
        logic [LEVEL_W-1:0] level;
    } verdict_t;

    class bucket_scoreboard;
        logic [RATE_W-1:0]  rate;
        logic [LEVEL_W-1:0] burst;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  last_ns;
        verdict_t           verdict_q[$];
        int mismatches, checked, items, restarts, denied, unlimited_items, stale_time, saturated;

        function new();
            rate    = '0;
            burst   = '0;
            level   = '0;
            last_ns = '0;
        endfunction

        function void write_reg(logic idx, logic [APB_DW-1:0] value);
            if (idx == REG_RATE) rate = value[RATE_W-1:0];
            else burst = value[LEVEL_W-1:0];
        endfunction

        function logic [LEVEL_W-1:0] bucket_cap();
            return (burst != 0) ? burst : LEVEL_W'(rate);
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function void flag(string msg);
            if (mismatches < 10) $display("mismatch at result %0d: %s", checked, msg);
            mismatches++;
        endfunction

        function void note_input(logic func, logic [TIME_W-1:0] now_ns,
                                 logic [BYTES_W-1:0] bytes);
            verdict_t             v;
            logic [TIME_W-1:0]    elapsed;
            logic [PROD_W-1:0]    product;
            logic [PROD_W-1:0]    gain;
            logic [LEVEL_W+1:0]   sum;
            v.allowed   = 1'b1;
            v.unlimited = (rate == 0);
            items++;
            if (func == FN_RESTART) begin
                restarts++;
                level   = bucket_cap();
                last_ns = now_ns;
            end else if (v.unlimited) begin
                unlimited_items++;
            end else begin
                if (now_ns > last_ns) begin
                    elapsed = now_ns - last_ns;
                    product = PROD_W'(elapsed) * PROD_W'(rate);
                    gain    = product / PROD_W'(NS_PER_SEC);
                    if (gain > GAIN_CEIL) begin
                        gain = GAIN_CEIL;
                        saturated++;
                    end
                    sum     = (LEVEL_W+2)'(level) + gain[LEVEL_W+1:0];
                    // a level left above a lowered burst is cut here
                    level   = (sum < (LEVEL_W+2)'(bucket_cap())) ? sum[LEVEL_W-1:0]
                                                                 : bucket_cap();
                    last_ns = now_ns;
                end else begin
                    stale_time++;
                end
                if (level >= LEVEL_W'(bytes)) begin
                    level = level - LEVEL_W'(bytes);
                end else begin
                    v.allowed = 1'b0;
                    denied++;
                end
            end
            v.level = level;
            verdict_q.push_back(v);
        endfunction

        function void check_result(logic allowed, logic unl, logic [LEVEL_W-1:0] lvl);
            verdict_t want;
            if (verdict_q.size() == 0) begin
                flag($sformatf("unexpected transfer allowed=%0b unlimited=%0b level=%0d",
                               allowed, unl, lvl));
                return;
            end
            want = verdict_q.pop_front();
            if (allowed !== want.allowed)
                flag($sformatf("allowed expected %0b, got %0b", want.allowed, allowed));
            if (unl !== want.unlimited)
                flag($sformatf("unlimited expected %0b, got %0b", want.unlimited, unl));
            if (lvl !== want.level)
                flag($sformatf("level_bytes expected %0d, got %0d", want.level, lvl));
            checked++;
        endfunction
    endclass

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_func         = 1'b0;
    logic [TIME_W-1:0]   s_now_time_ns  = '0;
    logic [BYTES_W-1:0]  s_packet_bytes = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic                m_allowed;
    logic                m_unlimited;
    logic [LEVEL_W-1:0]  m_level_bytes;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [APB_AW-1:0]   paddr          = '0;
    logic [APB_DW-1:0]   pwdata         = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    bucket_scoreboard    sb = new();
    bit                  calm = 1'b0;
    int                  hold_left = 0;
    int                  idle_cycles = 0;
    int                  settings = 0;
    logic [TIME_W-1:0]   cursor_ns = '0;

    token_bucket_rate_limiter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_now_time_ns  (s_now_time_ns),
        .s_packet_bytes (s_packet_bytes),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_allowed      (m_allowed),
        .m_unlimited    (m_unlimited),
        .m_level_bytes  (m_level_bytes),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // result side: check each transfer, stall in random bursts unless calm
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_allowed, m_unlimited, m_level_bytes);
        if (calm) begin
            m_ready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 12) begin
            hold_left = $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("token_bucket_rate_limiter verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic rest(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic send_item(logic func, logic [TIME_W-1:0] now_ns, logic [BYTES_W-1:0] bytes);
        if (!calm && $urandom_range(0, 99) < 25) rest($urandom_range(1, 10));
        s_valid        <= 1'b1;
        s_func         <= func;
        s_now_time_ns  <= now_ns;
        s_packet_bytes <= bytes;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(func, now_ns, bytes);
        cursor_ns = now_ns;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(logic idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic configure(logic [RATE_W-1:0] rate, logic [LEVEL_W-1:0] burst);
        drain();
        apb_write(REG_RATE, APB_DW'(rate));
        apb_write(REG_BURST, APB_DW'(burst));
        settings++;
    endtask

    task automatic directed_items();
        // reset settings: limiting off, restart leaves an empty bucket
        send_item(FN_REQUEST, '0, '0);
        send_item(FN_REQUEST, TIME_MAX, '1);
        send_item(FN_RESTART, 64'h0123_4567_89ab_cdef, '0);
        drain();
        apb_write(REG_BURST, 48'd5000);
        send_item(FN_RESTART, '0, '0);
        send_item(FN_REQUEST, 64'd10, '1);

        // burst of zero means one second of rate
        configure(40'd1_000_000, '0);
        send_item(FN_RESTART, 64'd1000, '0);
        send_item(FN_REQUEST, 64'd1000, '1);
        send_item(FN_REQUEST, 64'd500, '0);
        send_item(FN_REQUEST, 64'd3_000_001_000, '1);
        send_item(FN_REQUEST, 64'd3_000_001_001, 16'd1);

        // one token per second: fractional refill rounds down to nothing
        configure(40'd1, 48'd1);
        send_item(FN_RESTART, '0, '0);
        send_item(FN_REQUEST, 64'd1, 16'd1);
        send_item(FN_REQUEST, 64'd2, 16'd1);
        send_item(FN_REQUEST, 64'd1_000_000_002, 16'd1);
        send_item(FN_REQUEST, 64'd1_000_000_003, '0);

        // saturating refill, then a burst lowered under a full bucket
        configure(RATE_MAX, BURST_MAX);
        send_item(FN_RESTART, '0, '0);
        send_item(FN_REQUEST, TIME_HALF, '1);
        send_item(FN_REQUEST, TIME_HALF, '0);
        drain();
        apb_write(REG_BURST, 48'd100);
        send_item(FN_REQUEST, TIME_HALF, 16'd1000);
        send_item(FN_REQUEST, TIME_HALF + 64'd1, 16'd7);
        send_item(FN_REQUEST, TIME_MAX, '0);

        configure(RATE_MAX, '0);
        send_item(FN_RESTART, 64'd5, '0);
        send_item(FN_REQUEST, 64'd6, 16'h8000);
    endtask

    task automatic random_settings();
        logic [RATE_W-1:0]  rate;
        logic [LEVEL_W-1:0] burst;
        case ($urandom_range(0, 9))
            0: rate = '0;
            1: rate = RATE_W'(1);
            2: rate = RATE_MAX;
            3: rate = RATE_W'({$urandom, $urandom});
            default: rate = RATE_W'($urandom_range(1000, 200_000_000));
        endcase
        case ($urandom_range(0, 9))
            0: burst = '0;
            1: burst = LEVEL_W'(1);
            2: burst = BURST_MAX;
            3: burst = LEVEL_W'({$urandom, $urandom});
            default: burst = LEVEL_W'($urandom_range(1, 300_000));
        endcase
        configure(rate, burst);
    endtask

    task automatic random_item();
        logic               func;
        logic [TIME_W-1:0]  now_ns;
        logic [BYTES_W-1:0] bytes;
        int                 pick;
        func = ($urandom_range(0, 99) < 8) ? FN_RESTART : FN_REQUEST;
        pick = $urandom_range(0, 99);
        if (pick < 10)      now_ns = cursor_ns;
        else if (pick < 15) now_ns = cursor_ns - TIME_W'($urandom_range(1, 1_000_000));
        else if (pick < 55) now_ns = cursor_ns + TIME_W'($urandom_range(0, 100_000));
        else if (pick < 85) now_ns = cursor_ns + TIME_W'($urandom_range(0, 100_000_000));
        else if (pick < 95) now_ns = cursor_ns + TIME_W'($urandom);
        else                now_ns = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 50)
            bytes = BYTES_W'($urandom);
        else if (pick < 75 && sb.level < 48'd65536)
            // land right around the held level to hit the allow/deny edge
            bytes = BYTES_W'(sb.level) + BYTES_W'($urandom_range(0, 2)) - BYTES_W'(1);
        else
            bytes = BYTES_W'($urandom_range(0, 1500));
        send_item(func, now_ns, bytes);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_items();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            calm = (p == RANDOM_PHASES - 1);
            random_settings();
            if (p % 2 == 1) cursor_ns = {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0) send_item(FN_RESTART, cursor_ns, BYTES_W'($urandom));
            repeat (ITEMS_PER_PHASE) random_item();
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.flag($sformatf("%0d expected results never arrived", sb.pending()));
        $display("covered %0d items over %0d rate/burst settings: %0d restarts, %0d unlimited, %0d denied",
                 sb.items, settings, sb.restarts, sb.unlimited_items, sb.denied);
        $display("%0d requests without time advance, %0d saturated refills, %0d results checked",
                 sb.stale_time, sb.saturated, sb.checked);
        if (sb.mismatches == 0) begin
            $display("token_bucket_rate_limiter verification clean");
        end else begin
            $display("token_bucket_rate_limiter verification failed");
        end
        $finish;
    end

endmodule
